FILE: hdl/phs_pkg.sv
// Package for the 128-bit Pearson stream hash: types, codes, permutation table, mixing step.
package phs_pkg;

  localparam int BYTES_N  = 16;
  localparam int IDX_W    = 4;
  localparam int WORD_W   = 64;
  localparam int STATE_W  = 128;

  // Mixing rotations and shift
  localparam int ROT_W0   = 55;
  localparam int SHL_W1   = 14;
  localparam int ROT_W1   = 36;

  // Item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ABSORB = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_EMIT
  } state_t;

  // Controls for the byte shift register
  typedef struct packed {
    logic load;        // copy initial value
    logic shift;       // one chain step
    logic final_step;  // last chain step, apply mixing
  } sr_ctrl_t;

  localparam logic [7:0] PERM_TABLE [256] = '{
    8'h01, 8'h57, 8'h31, 8'h0c, 8'hb0, 8'hb2, 8'h66, 8'ha6,
    8'h79, 8'hc1, 8'h06, 8'h54, 8'hf9, 8'he6, 8'h2c, 8'ha3,
    8'h0e, 8'hc5, 8'hd5, 8'hb5, 8'ha1, 8'h55, 8'hda, 8'h50,
    8'h40, 8'hef, 8'h18, 8'he2, 8'hec, 8'h8e, 8'h26, 8'hc8,
    8'h6e, 8'hb1, 8'h68, 8'h67, 8'h8d, 8'hfd, 8'hff, 8'h32,
    8'h4d, 8'h65, 8'h51, 8'h12, 8'h2d, 8'h60, 8'h1f, 8'hde,
    8'h19, 8'h6b, 8'hbe, 8'h46, 8'h56, 8'hed, 8'hf0, 8'h22,
    8'h48, 8'hf2, 8'h14, 8'hd6, 8'hf4, 8'he3, 8'h95, 8'heb,
    8'h61, 8'hea, 8'h39, 8'h16, 8'h3c, 8'hfa, 8'h52, 8'haf,
    8'hd0, 8'h05, 8'h7f, 8'hc7, 8'h6f, 8'h3e, 8'h87, 8'hf8,
    8'hae, 8'ha9, 8'hd3, 8'h3a, 8'h42, 8'h9a, 8'h6a, 8'hc3,
    8'hf5, 8'hab, 8'h11, 8'hbb, 8'hb6, 8'hb3, 8'h00, 8'hf3,
    8'h84, 8'h38, 8'h94, 8'h4b, 8'h80, 8'h85, 8'h9e, 8'h64,
    8'h82, 8'h7e, 8'h5b, 8'h0d, 8'h99, 8'hf6, 8'hd8, 8'hdb,
    8'h77, 8'h44, 8'hdf, 8'h4e, 8'h53, 8'h58, 8'hc9, 8'h63,
    8'h7a, 8'h0b, 8'h5c, 8'h20, 8'h88, 8'h72, 8'h34, 8'h0a,
    8'h8a, 8'h1e, 8'h30, 8'hb7, 8'h9c, 8'h23, 8'h3d, 8'h1a,
    8'h8f, 8'h4a, 8'hfb, 8'h5e, 8'h81, 8'ha2, 8'h3f, 8'h98,
    8'haa, 8'h07, 8'h73, 8'ha7, 8'hf1, 8'hce, 8'h03, 8'h96,
    8'h37, 8'h3b, 8'h97, 8'hdc, 8'h5a, 8'h35, 8'h17, 8'h83,
    8'h7d, 8'had, 8'h0f, 8'hee, 8'h4f, 8'h5f, 8'h59, 8'h10,
    8'h69, 8'h89, 8'he1, 8'he0, 8'hd9, 8'ha0, 8'h25, 8'h7b,
    8'h76, 8'h49, 8'h02, 8'h9d, 8'h2e, 8'h74, 8'h09, 8'h91,
    8'h86, 8'he4, 8'hcf, 8'hd4, 8'hca, 8'hd7, 8'h45, 8'he5,
    8'h1b, 8'hbc, 8'h43, 8'h7c, 8'ha8, 8'hfc, 8'h2a, 8'h04,
    8'h1d, 8'h6c, 8'h15, 8'hf7, 8'h13, 8'hcd, 8'h27, 8'hcb,
    8'he9, 8'h28, 8'hba, 8'h93, 8'hc6, 8'hc0, 8'h9b, 8'h21,
    8'ha4, 8'hbf, 8'h62, 8'hcc, 8'ha5, 8'hb4, 8'h75, 8'h4c,
    8'h8c, 8'h24, 8'hd2, 8'hac, 8'h29, 8'h36, 8'h9f, 8'h08,
    8'hb9, 8'he8, 8'h71, 8'hc4, 8'he7, 8'h2f, 8'h92, 8'h78,
    8'h33, 8'h41, 8'h1c, 8'h90, 8'hfe, 8'hdd, 8'h5d, 8'hbd,
    8'hc2, 8'h8b, 8'h70, 8'h2b, 8'h47, 8'h6d, 8'hb8, 8'hd1
  };

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // xoroshiro128 step on {w1, w0}
  function automatic logic [STATE_W-1:0] mix128(input logic [STATE_W-1:0] s);
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    w0 = s[WORD_W-1:0];
    w1 = s[STATE_W-1:WORD_W] ^ w0;
    w0 = rotl64(w0, ROT_W0) ^ w1 ^ (w1 << SHL_W1);
    w1 = rotl64(w1, ROT_W1);
    return {w1, w0};
  endfunction

endpackage

FILE: hdl/phs_if.sv
// Valid/ready channel interfaces for key words and hash results.
interface phs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] init_low;
  logic [63:0] init_high;
  logic [7:0]  key_byte;
  logic        last;

  modport source (output valid, op, init_low, init_high, key_byte, last, input ready);
  modport sink   (input valid, op, init_low, init_high, key_byte, last, output ready);
endinterface

interface phs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_low;
  logic [63:0] hash_high;

  modport source (output valid, hash_low, hash_high, input ready);
  modport sink   (input valid, hash_low, hash_high, output ready);
endinterface

FILE: hdl/pearson_hash_128_stream_unit.sv
// Top level of the 128-bit Pearson stream hash: sequencer, state register, result register.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid / ready    op, init_low, init_high, key_byte, last
//   out_ch    out  valid / ready    hash_low, hash_high
//
// A load word copies its initial value into the state when accepted; a key word is
// accepted, then runs 16 chain steps, one byte per cycle through the single permutation
// table, the mixing step folded into the 16th. A word marked last then enters the emit
// state to move the state into the result register.
// rst_n (synchronous) clears the sequencer, the result valid flag and the hash
// state to zero. A result waiting on out_ch does not stop new words; only the
// next emit waits for the result register to drain, and input is held off meanwhile.
module pearson_hash_128_stream_unit
  import phs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  phs_in_if.sink   in_ch,
  phs_out_if.source out_ch
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [7:0]         key_r;
  logic               last_r;
  logic               out_valid_r, out_valid_nxt;
  logic [STATE_W-1:0] hash_r;
  logic [STATE_W-1:0] cur_state;
  logic [STATE_W-1:0] init_val;
  sr_ctrl_t           ctrl;
  logic               in_fire;
  logic               emit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Reset loads zero into the hash state
  assign init_val = rst_n ? {in_ch.init_high, in_ch.init_low} : '0;

  phs_state_sr u_sr (
    .clk      (clk),
    .ctrl     (ctrl),
    .init_val (init_val),
    .digit    (key_r + {4'b0, step_r}),
    .state    (cur_state)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    ctrl            = '0;
    emit            = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == OP_LOAD) begin
            ctrl.load = 1'b1;
            state_nxt = in_ch.last ? ST_EMIT : ST_IDLE;
          end else begin
            step_nxt  = '0;
            state_nxt = ST_ABSORB;
          end
        end
      end
      ST_ABSORB: begin
        step_nxt = step_r + 1'b1;
        if (step_r == IDX_W'(BYTES_N - 1)) begin
          ctrl.final_step = 1'b1;
          state_nxt       = last_r ? ST_EMIT : ST_IDLE;
        end else begin
          ctrl.shift = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (!rst_n) begin
      ctrl.load = 1'b1;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Word payload and result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r  <= in_ch.key_byte;
      last_r <= in_ch.last;
    end
    if (emit) begin
      hash_r <= cur_state;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hash_low  = hash_r[WORD_W-1:0];
  assign out_ch.hash_high = hash_r[STATE_W-1:WORD_W];

endmodule

FILE: hdl/phs_perm_rom.sv
// Byte permutation lookup table.
module phs_perm_rom
  import phs_pkg::*;
(
  input  logic [7:0] idx,
  output logic [7:0] val
);

  assign val = PERM_TABLE[idx];

endmodule

FILE: hdl/phs_state_sr.sv
// Hash state held as a 16-byte shift register; one chain step per cycle, mixing on the last.
module phs_state_sr
  import phs_pkg::*;
(
  input  logic               clk,
  input  sr_ctrl_t           ctrl,
  input  logic [STATE_W-1:0] init_val,
  input  logic [7:0]         digit,     // key byte plus step index, mod 256
  output logic [STATE_W-1:0] state
);

  // sr_r[0] sits at the byte position about to be replaced; sr_r[15] is the chain input.
  logic [7:0]         sr_r [BYTES_N];
  logic [7:0]         new_byte;
  logic [STATE_W-1:0] shifted;
  logic [STATE_W-1:0] mixed;

  phs_perm_rom u_rom (
    .idx (sr_r[BYTES_N-1] ^ digit),
    .val (new_byte)
  );

  // State after the final shift, packed little-endian
  always_comb begin
    for (int i = 0; i < BYTES_N - 1; i++) begin
      shifted[8*i +: 8] = sr_r[i+1];
    end
    shifted[8*(BYTES_N-1) +: 8] = new_byte;
  end

  assign mixed = mix128(shifted);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < BYTES_N; i++) begin
        sr_r[i] <= init_val[8*i +: 8];
      end
    end else if (ctrl.final_step) begin
      // last chain byte and the mixing step land together
      for (int i = 0; i < BYTES_N; i++) begin
        sr_r[i] <= mixed[8*i +: 8];
      end
    end else if (ctrl.shift) begin
      for (int i = 0; i < BYTES_N - 1; i++) begin
        sr_r[i] <= sr_r[i+1];
      end
      sr_r[BYTES_N-1] <= new_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < BYTES_N; i++) begin
      state[8*i +: 8] = sr_r[i];
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench for the 128-bit Pearson stream hash: random words, predicted digests, checked results.
`timescale 1ns / 100ps

module tb_top;
  import phs_pkg::*;

  // One input word as queued for the driver
  typedef struct {
    logic        op;
    bit   [63:0] init_low;
    bit   [63:0] init_high;
    bit   [7:0]  key_byte;
    bit          last;
    bit          drain;  // hold this word until every digest has come back
  } key_word_t;

  typedef struct {
    bit [63:0] lo;
    bit [63:0] hi;
  } digest_t;

  logic clk;
  logic rst_n;

  phs_in_if  in_ch ();
  phs_out_if out_ch ();

  pearson_hash_128_stream_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_word_t word_queue[$];
  digest_t   digest_queue[$];
  key_word_t drv_word;
  digest_t   want;
  bit [127:0] hash_state;
  int        err_count;
  int        word_total;
  bit        word_taken;
  bit        digest_taken;
  int        send_gap;
  int        send_calm;
  int        recv_stall;
  int        recv_calm;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle draw: usually a random idle gap, with occasional stretches of no idling
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One key byte: chain through the permutation, then the xoroshiro128 step
  function automatic void absorb_key(input bit [7:0] k);
    bit [7:0]  step_key;
    bit [63:0] lo;
    bit [63:0] hi;
    hash_state[7:0] = PERM_TABLE[hash_state[127:120] ^ k];
    for (int j = 1; j < BYTES_N; j++) begin
      step_key = k + 8'(j);
      hash_state[8*j +: 8] = PERM_TABLE[hash_state[8*(j-1) +: 8] ^ step_key];
    end
    lo = hash_state[63:0];
    hi = hash_state[127:64] ^ lo;
    lo = ((lo << ROT_W0) | (lo >> (WORD_W - ROT_W0))) ^ hi ^ (hi << SHL_W1);
    hi = (hi << ROT_W1) | (hi >> (WORD_W - ROT_W1));
    hash_state = {hi, lo};
  endfunction

  // Update the predicted state for an accepted word, queue a digest on last
  function automatic void track_word(input key_word_t w);
    if (w.op == OP_LOAD) begin
      hash_state = {w.init_high, w.init_low};
    end else begin
      absorb_key(w.key_byte);
    end
    if (w.last) begin
      digest_queue.push_back('{lo: hash_state[63:0], hi: hash_state[127:64]});
    end
  endfunction

  function automatic void add_word(input logic op, input bit [7:0] key, input bit last,
                                   input bit drain);
    key_word_t w;
    w.op        = op;
    w.init_low  = rand64();
    w.init_high = rand64();
    w.key_byte  = key;
    w.last      = last;
    w.drain     = drain;
    word_queue.push_back(w);
    word_total++;
  endfunction

  function automatic void add_load(input bit [63:0] lo, input bit [63:0] hi, input bit last);
    key_word_t w;
    w.op        = OP_LOAD;
    w.init_low  = lo;
    w.init_high = hi;
    w.key_byte  = 8'($urandom_range(0, 255));
    w.last      = last;
    w.drain     = 1'b0;
    word_queue.push_back(w);
    word_total++;
  endfunction

  // Input acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      word_taken = 1'b1;
      track_word(drv_word);
    end
  end

  // Input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      word_taken = 1'b0;
    end else if (!in_ch.valid || word_taken) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (word_queue.size() > 0 &&
                   !(word_queue[0].drain && digest_queue.size() > 0)) begin
        drv_word = word_queue.pop_front();
        in_ch.op        <= drv_word.op;
        in_ch.init_low  <= drv_word.init_low;
        in_ch.init_high <= drv_word.init_high;
        in_ch.key_byte  <= drv_word.key_byte;
        in_ch.last      <= drv_word.last;
        in_ch.valid     <= 1'b1;
        send_gap = draw_gap(send_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      digest_taken = 1'b1;
      if (digest_queue.size() == 0) begin
        $display("%0t unexpected result: hash_high %h hash_low %h",
                 $time, out_ch.hash_high, out_ch.hash_low);
        err_count++;
      end else begin
        want = digest_queue.pop_front();
        if (out_ch.hash_low !== want.lo) begin
          $display("%0t hash_low mismatch: expected %h actual %h",
                   $time, want.lo, out_ch.hash_low);
          err_count++;
        end
        if (out_ch.hash_high !== want.hi) begin
          $display("%0t hash_high mismatch: expected %h actual %h",
                   $time, want.hi, out_ch.hash_high);
          err_count++;
        end
      end
    end
  end

  // Result ready with random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      digest_taken = 1'b0;
    end else begin
      if (digest_taken) begin
        digest_taken = 1'b0;
        recv_stall = draw_gap(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int      msg_len;
    int      pick;
    int      tail;
    bit      hold;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_LOAD;
    in_ch.init_low  = '0;
    in_ch.init_high = '0;
    in_ch.key_byte  = '0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    err_count  = 0;
    word_total = 0;
    hash_state = '0;
    send_gap   = 0;
    send_calm  = 0;
    recv_stall = 0;
    recv_calm  = 0;

    // Directed: key bytes on the reset state, before any load
    add_word(OP_ABSORB, 8'h00, 1'b0, 1'b0);
    add_word(OP_ABSORB, 8'hff, 1'b1, 1'b0);
    // Empty keys return the loaded value
    add_load('0, '0, 1'b1);
    add_load('1, '1, 1'b1);
    // Key bytes whose index sums wrap past 255, then one whose sums do not
    add_load('1, '1, 1'b0);
    add_word(OP_ABSORB, 8'hff, 1'b1, 1'b0);
    add_load(rand64(), rand64(), 1'b0);
    add_word(OP_ABSORB, 8'hf1, 1'b0, 1'b0);
    add_word(OP_ABSORB, 8'hfe, 1'b0, 1'b0);
    add_word(OP_ABSORB, 8'h80, 1'b1, 1'b0);
    // Continue hashing after a result
    add_word(OP_ABSORB, 8'h01, 1'b1, 1'b0);
    // Reload over an unfinished message
    add_load(rand64(), rand64(), 1'b0);
    add_load(64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef, 1'b1);
    add_load(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_word(OP_ABSORB, 8'h7f, 1'b1, 1'b1);
    add_word(OP_ABSORB, 8'h00, 1'b1, 1'b0);

    // Random: mostly load + key bytes + last, some continuations and noise
    while (word_total < 1500) begin
      pick = $urandom_range(0, 9);
      hold = ($urandom_range(0, 149) == 0);
      if (pick < 8) begin
        if ($urandom_range(0, 9) == 0) msg_len = 0;
        else if ($urandom_range(0, 7) == 0) msg_len = $urandom_range(7, 24);
        else msg_len = $urandom_range(1, 6);
        add_load(rand64(), rand64(), msg_len == 0);
        if (hold) word_queue[$].drain = 1'b1;
        for (int i = 0; i < msg_len; i++) begin
          add_word(OP_ABSORB, 8'($urandom_range(0, 255)), i == msg_len - 1, 1'b0);
        end
      end else if (pick == 8) begin
        msg_len = $urandom_range(1, 4);
        for (int i = 0; i < msg_len; i++) begin
          add_word(OP_ABSORB, 8'($urandom_range(0, 255)), i == msg_len - 1, hold && i == 0);
        end
      end else begin
        add_word($urandom_range(0, 1) ? OP_ABSORB : OP_LOAD, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), hold);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all words to go in, then for the digests to drain
    while (word_queue.size() > 0 || in_ch.valid) @(negedge clk);
    for (tail = 0; tail < 3000 && digest_queue.size() > 0; tail++) @(negedge clk);
    repeat (40) @(negedge clk);
    if (digest_queue.size() > 0) begin
      $display("%0t %0d results never arrived, next expected hash_high %h hash_low %h",
               $time, digest_queue.size(), digest_queue[0].hi, digest_queue[0].lo);
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
